### src/gdn_pkg.sv
// ============================================================================
// gdn_pkg
// Shared types, constants and calendar helper functions for the Gregorian
// day-number converter.
// ============================================================================
package gdn_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int SERIAL_W = 22;
    localparam int WDAY_W   = 3;
    localparam int DOY_W    = 9;

    localparam logic [YEAR_W-1:0]   MAX_YEAR   = 14'd9999;
    localparam logic [SERIAL_W-1:0] MAX_SERIAL = 22'd3652059;
    localparam logic [MONTH_W-1:0]  MONTHS     = 4'd12;

    localparam logic [17:0] DAYS_400Y = 18'd146097;
    localparam logic [15:0] DAYS_100Y = 16'd36524;
    localparam logic [10:0] DAYS_4Y   = 11'd1461;
    localparam logic [8:0]  DAYS_1Y   = 9'd365;

    // Reciprocal constants: q = (x * MUL) >> SH, exact over the used input range.
    localparam int          DIV100_SH   = 24;
    localparam logic [17:0] DIV100_MUL  = 18'((64'd1 << DIV100_SH) / 64'd100 + 64'd1);
    localparam int          DIV400Y_SH  = 40;
    localparam logic [22:0] DIV400Y_MUL = 23'((64'd1 << DIV400Y_SH) / 64'd146097 + 64'd1);
    localparam int          DIV4Y_SH    = 28;
    localparam logic [17:0] DIV4Y_MUL   = 18'((64'd1 << DIV4Y_SH) / 64'd1461 + 64'd1);

    typedef enum logic
    {
        FUNC_DATE_TO_SERIAL = 1'b0,
        FUNC_SERIAL_TO_DATE = 1'b1
    } func_t;

    typedef struct packed
    {
        logic                  func;
        logic [YEAR_W-1:0]     year_in;
        logic [MONTH_W-1:0]    month_in;
        logic [DAY_W-1:0]      day_in;
        logic [SERIAL_W-1:0]   serial_in;
    } gdn_in_t;

    typedef struct packed
    {
        logic [SERIAL_W-1:0]   serial_out;
        logic [YEAR_W-1:0]     year_out;
        logic [MONTH_W-1:0]    month_out;
        logic [DAY_W-1:0]      day_out;
        logic [WDAY_W-1:0]     weekday;
        logic                  leap;
        logic                  error;
    } gdn_out_t;

    // Length of month m; zero for a month code outside 1..12.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of the year that come before the first of month m.
    function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DOY_W-1:0] base;
        logic [DOY_W-1:0] adj;
        unique case (m)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        adj = (leap && (m >= 4'd3)) ? 9'd1 : 9'd0;
        return base + adj;
    endfunction

endpackage

### src/gregorian_day_number_converter_unit.sv
// ============================================================================
// gregorian_day_number_converter_unit
// Proleptic Gregorian date <-> serial day number converter, 8-stage pipeline.
// ============================================================================
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one request beat: func
//   selects date -> serial (0) or serial -> date (1). Output channel
//   (out_valid/out_ready/out_data) returns exactly one result beat per
//   request, in order. Day 1 is 0001-01-01, a Monday.
//   Rejected requests (bad date, serial outside 1..3652059) come back with
//   error set and all other fields zero.
// Pipeline and throughput:
//   out_valid rises once a request has passed all 8 register stages, the
//   first loaded at the accepting edge; one beat per cycle sustained while
//   out_ready is high. Depth is set by the serial -> date path: divide by
//   400-year span, 100-year ladder, divide by 4-year span, year ladder, month
//   split, weekday fold, each stage about one multiply or one add/compare deep.
// Stalls:
//   Each stage advances when it is empty or the next stage advances, so
//   bubbles close up and new beats are taken while a finished result waits
//   on out_ready. Nothing is dropped or repeated.
// Reset:
//   rst_n clears all stage valid bits; the pipeline comes up empty.
//
module gregorian_day_number_converter_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gdn_pkg::gdn_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output gdn_pkg::gdn_out_t out_data
);

    localparam int STAGES = 8;

    // Request info carried down to the direction select (serial is serial_in).
    typedef struct packed
    {
        logic                          func;
        logic [gdn_pkg::SERIAL_W-1:0]  serial;
        logic                          range_err;
    } ctl_t;

    // A complete result before weekday is added.
    typedef struct packed
    {
        logic                          err;
        logic                          leap;
        logic [gdn_pkg::YEAR_W-1:0]    year;
        logic [gdn_pkg::MONTH_W-1:0]   month;
        logic [gdn_pkg::DAY_W-1:0]     day;
        logic [gdn_pkg::SERIAL_W-1:0]  serial;
    } res_t;

    logic [STAGES:1] valid_reg;
    logic [STAGES:1] adv;

    // ---------------- handshake / advance chain ----------------
    always_comb
    begin
        adv[STAGES] = !valid_reg[STAGES] || out_ready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_ready  = adv[1];
    assign out_valid = valid_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= in_valid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: offsets and first reciprocal multiplies ----------------
    ctl_t                           s1_ctl_next;
    logic [gdn_pkg::YEAR_W-1:0]     s1_p_next;
    logic [31:0]                    s1_mulp;
    logic [31:0]                    s1_muly;
    logic [gdn_pkg::SERIAL_W-1:0]   s1_n;
    logic [44:0]                    s1_mul400;

    assign s1_p_next = in_data.year_in - 14'd1;
    assign s1_mulp   = 32'(s1_p_next) * 32'(gdn_pkg::DIV100_MUL);
    assign s1_muly   = 32'(in_data.year_in) * 32'(gdn_pkg::DIV100_MUL);
    assign s1_n      = in_data.serial_in - 22'd1;
    assign s1_mul400 = 45'(s1_n) * 45'(gdn_pkg::DIV400Y_MUL);

    assign s1_ctl_next.func      = in_data.func;
    assign s1_ctl_next.serial    = in_data.serial_in;
    assign s1_ctl_next.range_err = (in_data.serial_in == 22'd0) ||
                                   (in_data.serial_in > gdn_pkg::MAX_SERIAL);

    ctl_t                           s1_ctl_reg;
    logic [gdn_pkg::YEAR_W-1:0]     s1_year_reg;
    logic [gdn_pkg::MONTH_W-1:0]    s1_month_reg;
    logic [gdn_pkg::DAY_W-1:0]      s1_day_reg;
    logic [gdn_pkg::YEAR_W-1:0]     s1_p_reg;
    logic [7:0]                     s1_q100p_reg;
    logic [7:0]                     s1_q100y_reg;
    logic [4:0]                     s1_q400_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_ctl_reg   <= s1_ctl_next;
            s1_year_reg  <= in_data.year_in;
            s1_month_reg <= in_data.month_in;
            s1_day_reg   <= in_data.day_in;
            s1_p_reg     <= s1_p_next;
            s1_q100p_reg <= s1_mulp[31:24];
            s1_q100y_reg <= s1_muly[31:24];
            s1_q400_reg  <= s1_mul400[44:40];
        end
    end

    // ---------------- stage 2: leap, validation, year base; 400-year remainder ----------------
    logic [gdn_pkg::YEAR_W-1:0]     s2_y100;
    logic                           s2_leap_next;
    logic                           s2_err_next;
    logic [gdn_pkg::SERIAL_W-1:0]   s2_base_next;
    logic [gdn_pkg::SERIAL_W-1:0]   s2_n;
    logic [gdn_pkg::SERIAL_W-1:0]   s2_span;

    assign s2_y100      = 14'(s1_q100y_reg) * 14'd100;
    assign s2_leap_next = (s1_year_reg[1:0] == 2'b00) &&
                          ((s1_year_reg != s2_y100) || (s1_q100y_reg[1:0] == 2'b00));
    assign s2_err_next  = !((s1_year_reg >= 14'd1) && (s1_year_reg <= gdn_pkg::MAX_YEAR) &&
                            (s1_month_reg >= 4'd1) && (s1_month_reg <= gdn_pkg::MONTHS) &&
                            (s1_day_reg >= 5'd1) &&
                            (s1_day_reg <= gdn_pkg::month_len(s1_month_reg, s2_leap_next)));
    // days in years 1 .. y-1 = p*365 + p/4 - p/100 + p/400
    assign s2_base_next = 22'(s1_p_reg) * 22'(gdn_pkg::DAYS_1Y) + 22'(s1_p_reg[13:2])
                          - 22'(s1_q100p_reg) + 22'(s1_q100p_reg[7:2]);
    assign s2_n         = s1_ctl_reg.serial - 22'd1;
    assign s2_span      = 22'(s1_q400_reg) * 22'(gdn_pkg::DAYS_400Y);

    ctl_t                           s2_ctl_reg;
    logic [gdn_pkg::YEAR_W-1:0]     s2_year_reg;
    logic [gdn_pkg::MONTH_W-1:0]    s2_month_reg;
    logic [gdn_pkg::DAY_W-1:0]      s2_day_reg;
    logic                           s2_leap_reg;
    logic                           s2_err_reg;
    logic [gdn_pkg::SERIAL_W-1:0]   s2_base_reg;
    logic [gdn_pkg::DOY_W-1:0]      s2_cum_reg;
    logic [17:0]                    s2_r400_reg;
    logic [gdn_pkg::YEAR_W-1:0]     s2_y400_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_ctl_reg   <= s1_ctl_reg;
            s2_year_reg  <= s1_year_reg;
            s2_month_reg <= s1_month_reg;
            s2_day_reg   <= s1_day_reg;
            s2_leap_reg  <= s2_leap_next;
            s2_err_reg   <= s2_err_next;
            s2_base_reg  <= s2_base_next;
            s2_cum_reg   <= gdn_pkg::cum_days(s1_month_reg, s2_leap_next);
            s2_r400_reg  <= 18'(s2_n - s2_span);
            s2_y400_reg  <= 14'(s1_q400_reg) * 14'd400;
        end
    end

    // ---------------- stage 3: forward serial done; 100-year ladder ----------------
    res_t                           s3_fwd_next;
    logic [1:0]                     s3_q100_next;
    logic [15:0]                    s3_r100_next;

    assign s3_fwd_next.err    = s2_err_reg;
    assign s3_fwd_next.leap   = s2_leap_reg;
    assign s3_fwd_next.year   = s2_year_reg;
    assign s3_fwd_next.month  = s2_month_reg;
    assign s3_fwd_next.day    = s2_day_reg;
    assign s3_fwd_next.serial = s2_base_reg + 22'(s2_cum_reg) + 22'(s2_day_reg);

    // last century of a 400-year span absorbs the leap day, so cap at 3
    always_comb
    begin
        priority if (s2_r400_reg >= 18'(3 * gdn_pkg::DAYS_100Y))
        begin
            s3_q100_next = 2'd3;
        end
        else if (s2_r400_reg >= 18'(2 * gdn_pkg::DAYS_100Y))
        begin
            s3_q100_next = 2'd2;
        end
        else if (s2_r400_reg >= 18'(gdn_pkg::DAYS_100Y))
        begin
            s3_q100_next = 2'd1;
        end
        else
        begin
            s3_q100_next = 2'd0;
        end
    end

    assign s3_r100_next = 16'(s2_r400_reg - 18'(s3_q100_next) * 18'(gdn_pkg::DAYS_100Y));

    ctl_t                           s3_ctl_reg;
    res_t                           s3_fwd_reg;
    logic [1:0]                     s3_q100_reg;
    logic [15:0]                    s3_r100_reg;
    logic [gdn_pkg::YEAR_W-1:0]     s3_yb_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_ctl_reg  <= s2_ctl_reg;
            s3_fwd_reg  <= s3_fwd_next;
            s3_q100_reg <= s3_q100_next;
            s3_r100_reg <= s3_r100_next;
            s3_yb_reg   <= s2_y400_reg + 14'(s3_q100_next) * 14'd100;
        end
    end

    // ---------------- stage 4: divide by 4-year span ----------------
    logic [33:0] s4_mul4;

    assign s4_mul4 = 34'(s3_r100_reg) * 34'(gdn_pkg::DIV4Y_MUL);

    ctl_t                           s4_ctl_reg;
    res_t                           s4_fwd_reg;
    logic [1:0]                     s4_q100_reg;
    logic [15:0]                    s4_r100_reg;
    logic [gdn_pkg::YEAR_W-1:0]     s4_yb_reg;
    logic [4:0]                     s4_q4_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_ctl_reg  <= s3_ctl_reg;
            s4_fwd_reg  <= s3_fwd_reg;
            s4_q100_reg <= s3_q100_reg;
            s4_r100_reg <= s3_r100_reg;
            s4_yb_reg   <= s3_yb_reg;
            s4_q4_reg   <= s4_mul4[32:28];
        end
    end

    // ---------------- stage 5: 4-year remainder ----------------
    ctl_t                           s5_ctl_reg;
    res_t                           s5_fwd_reg;
    logic [10:0]                    s5_r4_reg;
    logic [gdn_pkg::YEAR_W-1:0]     s5_yb_reg;
    logic                           s5_leapok_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_ctl_reg    <= s4_ctl_reg;
            s5_fwd_reg    <= s4_fwd_reg;
            s5_r4_reg     <= 11'(s4_r100_reg - 16'(s4_q4_reg) * 16'(gdn_pkg::DAYS_4Y));
            s5_yb_reg     <= s4_yb_reg + 14'({s4_q4_reg, 2'b00});
            // quad 24 of a century ends on a century year: leap only every 400
            s5_leapok_reg <= (s4_q4_reg != 5'd24) || (s4_q100_reg == 2'd3);
        end
    end

    // ---------------- stage 6: year ladder, day of year ----------------
    logic [1:0] s6_q1_next;

    always_comb
    begin
        priority if (s5_r4_reg >= 11'(3 * gdn_pkg::DAYS_1Y))
        begin
            s6_q1_next = 2'd3;
        end
        else if (s5_r4_reg >= 11'(2 * gdn_pkg::DAYS_1Y))
        begin
            s6_q1_next = 2'd2;
        end
        else if (s5_r4_reg >= 11'(gdn_pkg::DAYS_1Y))
        begin
            s6_q1_next = 2'd1;
        end
        else
        begin
            s6_q1_next = 2'd0;
        end
    end

    ctl_t                           s6_ctl_reg;
    res_t                           s6_fwd_reg;
    logic [gdn_pkg::DOY_W-1:0]      s6_doy_reg;
    logic [gdn_pkg::YEAR_W-1:0]     s6_year_reg;
    logic                           s6_leap_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_ctl_reg  <= s5_ctl_reg;
            s6_fwd_reg  <= s5_fwd_reg;
            s6_doy_reg  <= 9'(s5_r4_reg - 11'(s6_q1_next) * 11'(gdn_pkg::DAYS_1Y));
            s6_year_reg <= s5_yb_reg + 14'(s6_q1_next) + 14'd1;
            s6_leap_reg <= (s6_q1_next == 2'd3) && s5_leapok_reg;
        end
    end

    // ---------------- stage 7: month split and direction select ----------------
    logic [gdn_pkg::MONTH_W-1:0] s7_month;
    logic [gdn_pkg::DAY_W-1:0]   s7_day;
    res_t                        s7_sel;
    res_t                        s7_res_next;

    gdn_doy_split u_doy_split
    (
        .doy   (s6_doy_reg),
        .leap  (s6_leap_reg),
        .month (s7_month),
        .day   (s7_day)
    );

    always_comb
    begin
        if (s6_ctl_reg.func == gdn_pkg::FUNC_SERIAL_TO_DATE)
        begin
            s7_sel.err    = s6_ctl_reg.range_err;
            s7_sel.leap   = s6_leap_reg;
            s7_sel.year   = s6_year_reg;
            s7_sel.month  = s7_month;
            s7_sel.day    = s7_day;
            s7_sel.serial = s6_ctl_reg.serial;
        end
        else
        begin
            s7_sel = s6_fwd_reg;
        end
        s7_res_next = s7_sel.err ? res_t'{err: 1'b1, default: '0} : s7_sel;
    end

    res_t s7_res_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_res_reg <= s7_res_next;
        end
    end

    // ---------------- stage 8: weekday, output register ----------------
    logic [gdn_pkg::WDAY_W-1:0] s8_wday;
    gdn_pkg::gdn_out_t          out_data_next;
    gdn_pkg::gdn_out_t          out_data_reg;

    gdn_weekday u_weekday
    (
        .serial  (s7_res_reg.serial),
        .weekday (s8_wday)
    );

    assign out_data_next.serial_out = s7_res_reg.serial;
    assign out_data_next.year_out   = s7_res_reg.year;
    assign out_data_next.month_out  = s7_res_reg.month;
    assign out_data_next.day_out    = s7_res_reg.day;
    assign out_data_next.weekday    = s7_res_reg.err ? 3'd0 : s8_wday;
    assign out_data_next.leap       = s7_res_reg.leap;
    assign out_data_next.error      = s7_res_reg.err;

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_data = out_data_reg;

    // ---------------- assertions ----------------
    // accepted beat lands in stage 1
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[1])
        else $error("accepted beat did not reach stage 1");

    // error beats carry all-zero fields
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error) |->
        (out_data.serial_out == 22'd0 && out_data.year_out == 14'd0 &&
         out_data.month_out == 4'd0 && out_data.day_out == 5'd0 &&
         out_data.weekday == 3'd0 && !out_data.leap))
        else $error("error result with nonzero fields");

    // good results have a real month and weekday and a nonzero day
    a_good_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.error) |->
        (out_data.month_out >= 4'd1 && out_data.month_out <= 4'd12 &&
         out_data.weekday >= 3'd1 && out_data.weekday <= 3'd7 &&
         out_data.day_out >= 5'd1))
        else $error("month, day or weekday out of range");

    // leap flag only on years divisible by four
    a_leap_div4: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.leap) |-> (out_data.year_out[1:0] == 2'b00))
        else $error("leap flag on a year not divisible by four");

endmodule

### src/gdn_doy_split.sv
// ============================================================================
// gdn_doy_split
// Splits a zero-based day of year into month and 1-based day of month.
// ============================================================================
module gdn_doy_split
(
    input  logic [gdn_pkg::DOY_W-1:0]   doy,
    input  logic                        leap,
    output logic [gdn_pkg::MONTH_W-1:0] month,
    output logic [gdn_pkg::DAY_W-1:0]   day
);

    logic [gdn_pkg::MONTH_W-1:0] passed;

    // count month starts at or below doy (Feb..Dec), independent compares
    always_comb
    begin
        passed = '0;
        for (int j = 2; j <= 12; j++)
        begin
            if (doy >= gdn_pkg::cum_days(4'(j), leap))
            begin
                passed = passed + 4'd1;
            end
        end
    end

    assign month = passed + 4'd1;
    assign day   = 5'(doy - gdn_pkg::cum_days(month, leap) + 9'd1);

endmodule

### src/gdn_weekday.sv
// ============================================================================
// gdn_weekday
// ISO weekday of a serial day number (Monday 1 .. Sunday 7), mod 7 by
// folding octal digits since 8 = 1 mod 7.
// ============================================================================
module gdn_weekday
(
    input  logic [gdn_pkg::SERIAL_W-1:0] serial,
    output logic [gdn_pkg::WDAY_W-1:0]   weekday
);

    logic [5:0] digit_sum;
    logic [3:0] fold;
    logic [2:0] rem;

    always_comb
    begin
        digit_sum = 6'(serial[21]);
        for (int k = 0; k < 7; k++)
        begin
            digit_sum = digit_sum + 6'(serial[3*k +: 3]);
        end
    end

    assign fold = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
    // fold <= 12; one subtract leaves 0..6, where 0 means Sunday
    assign rem  = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];

    assign weekday = (rem == 3'd0) ? 3'd7 : rem;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the Gregorian day-number converter. Date and
// serial requests go in through the valid/ready input channel. A scoreboard
// class predicts every result beat in order and compares it field by field.
// Both channels idle at random, except for one stretch with no gaps at all.
// ============================================================================
module tb_top;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts one result per accepted request and keeps the
    // expected beats in arrival order.
    // ------------------------------------------------------------------------
    class day_number_scoreboard;

        gdn_pkg::gdn_out_t pending_results[$];
        int unsigned       failures;
        int unsigned       checked_beats;
        int unsigned       date_requests;
        int unsigned       serial_requests;
        int unsigned       rejections;

        function new();
            failures        = 0;
            checked_beats   = 0;
            date_requests   = 0;
            serial_requests = 0;
            rejections      = 0;
        endfunction

        function bit is_leap_year(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // Month length for month 1..12; callers range-check m first.
        function int unsigned days_in_month(int unsigned y, int unsigned m);
            case (m)
                4, 6, 9, 11: return 30;
                2:           return is_leap_year(y) ? 29 : 28;
                default:     return 31;
            endcase
        endfunction

        // Full conversion in either direction, rejections zeroed with error set.
        function gdn_pkg::gdn_out_t convert_calendar(gdn_pkg::gdn_in_t req);
            int unsigned       y, m, d, s, n;
            int unsigned       q400, q100, q4, q1;
            gdn_pkg::gdn_out_t res;
            res = '0;
            if (req.func == gdn_pkg::FUNC_DATE_TO_SERIAL)
            begin
                y = req.year_in;
                m = req.month_in;
                d = req.day_in;
                if (y < 1 || y > gdn_pkg::MAX_YEAR || m < 1 || m > gdn_pkg::MONTHS ||
                    d < 1 || d > days_in_month(y, m))
                begin
                    res.error = 1'b1;
                    return res;
                end
                n = y - 1;
                s = n * 365 + n / 4 - n / 100 + n / 400;
                for (int j = 1; j < m; j++)
                    s += days_in_month(y, j);
                s += d;
            end
            else
            begin
                s = req.serial_in;
                if (s < 1 || s > gdn_pkg::MAX_SERIAL)
                begin
                    res.error = 1'b1;
                    return res;
                end
                n    = s - 1;
                q400 = n / gdn_pkg::DAYS_400Y;
                n    = n % gdn_pkg::DAYS_400Y;
                q100 = n / gdn_pkg::DAYS_100Y;
                if (q100 > 3)
                    q100 = 3;   // last day of a 400-year cycle
                n    = n - q100 * gdn_pkg::DAYS_100Y;
                q4   = n / gdn_pkg::DAYS_4Y;
                n    = n % gdn_pkg::DAYS_4Y;
                q1   = n / gdn_pkg::DAYS_1Y;
                if (q1 > 3)
                    q1 = 3;     // day 366 of a leap year
                n    = n - q1 * gdn_pkg::DAYS_1Y;
                y    = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
                m    = 1;
                while (m < 12 && n >= days_in_month(y, m))
                begin
                    n = n - days_in_month(y, m);
                    m++;
                end
                d = n + 1;
            end
            res.serial_out = s[gdn_pkg::SERIAL_W-1:0];
            res.year_out   = y[gdn_pkg::YEAR_W-1:0];
            res.month_out  = m[gdn_pkg::MONTH_W-1:0];
            res.day_out    = d[gdn_pkg::DAY_W-1:0];
            res.weekday    = (s % 7 == 0) ? 3'd7 : 3'(s % 7);
            res.leap       = is_leap_year(y);
            res.error      = 1'b0;
            return res;
        endfunction

        function void note_request(gdn_pkg::gdn_in_t req);
            gdn_pkg::gdn_out_t res;
            res = convert_calendar(req);
            if (req.func == gdn_pkg::FUNC_DATE_TO_SERIAL)
                date_requests++;
            else
                serial_requests++;
            if (res.error)
                rejections++;
            pending_results.push_back(res);
        endfunction

        function void check_result(gdn_pkg::gdn_out_t got);
            gdn_pkg::gdn_out_t want;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request outstanding: %p", got);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            checked_beats++;
            if (got.serial_out !== want.serial_out)
            begin
                $error("serial_out: expected %0d, got %0d", want.serial_out, got.serial_out);
                failures++;
            end
            if (got.year_out !== want.year_out)
            begin
                $error("year_out: expected %0d, got %0d", want.year_out, got.year_out);
                failures++;
            end
            if (got.month_out !== want.month_out)
            begin
                $error("month_out: expected %0d, got %0d", want.month_out, got.month_out);
                failures++;
            end
            if (got.day_out !== want.day_out)
            begin
                $error("day_out: expected %0d, got %0d", want.day_out, got.day_out);
                failures++;
            end
            if (got.weekday !== want.weekday)
            begin
                $error("weekday: expected %0d, got %0d", want.weekday, got.weekday);
                failures++;
            end
            if (got.leap !== want.leap)
            begin
                $error("leap: expected %0d, got %0d", want.leap, got.leap);
                failures++;
            end
            if (got.error !== want.error)
            begin
                $error("error: expected %0d, got %0d", want.error, got.error);
                failures++;
            end
        endfunction

    endclass

    // Cycles without any beat on either channel before the run is abandoned.
    // The pipe is 8 deep.
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned RANDOM_BEATS = 1150;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    gdn_pkg::gdn_in_t  in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    gdn_pkg::gdn_out_t out_data;

    // High during one window of the random phase: no gaps on either side.
    logic     steady_flow = 1'b0;

    day_number_scoreboard sb = new();

    gregorian_day_number_converter_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 2 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: back-pressure with about 36 percent probability, none while steady.
    always @(posedge clk)
    begin
        out_ready <= steady_flow || ($urandom_range(99) >= 36);
    end

    // Result monitor. Values read at the edge are the pre-edge ones, i.e.
    // the ones that decide whether a beat moves at this edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Watchdog: counts edges at which no beat moves on either channel.
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $error("no beat moved for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request builders. The field that the selected direction ignores is
    // filled with noise so its bits toggle too.
    // ------------------------------------------------------------------------
    function automatic gdn_pkg::gdn_in_t date_request(int unsigned y, int unsigned m,
                                                      int unsigned d);
        gdn_pkg::gdn_in_t req;
        req.func      = gdn_pkg::FUNC_DATE_TO_SERIAL;
        req.year_in   = y[gdn_pkg::YEAR_W-1:0];
        req.month_in  = m[gdn_pkg::MONTH_W-1:0];
        req.day_in    = d[gdn_pkg::DAY_W-1:0];
        req.serial_in = 22'($urandom_range(4194303, 0));
        return req;
    endfunction

    function automatic gdn_pkg::gdn_in_t serial_request(int unsigned s);
        gdn_pkg::gdn_in_t req;
        req.func      = gdn_pkg::FUNC_SERIAL_TO_DATE;
        req.year_in   = 14'($urandom_range(16383, 0));
        req.month_in  = 4'($urandom_range(15, 0));
        req.day_in    = 5'($urandom_range(31, 0));
        req.serial_in = s[gdn_pkg::SERIAL_W-1:0];
        return req;
    endfunction

    // Sender: optional random gap, then hold the beat until in_ready.
    // Exactly one NBA to in_valid per edge: either the gap low or the next high.
    task automatic send_request(input gdn_pkg::gdn_in_t req);
        while (!steady_flow && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(req);
    endtask

    // Random request mix: mostly well-formed dates and in-range serials,
    // with weight on month ends, century years and year boundaries.
    function automatic gdn_pkg::gdn_in_t random_request();
        int unsigned       pick, y, m, d, len, s;
        gdn_pkg::gdn_in_t  req;
        gdn_pkg::gdn_out_t year_end;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            // valid date, sometimes pushed to the edge of its month
            if ($urandom_range(9) < 2)
                y = 100 * $urandom_range(99, 1);        // century years
            else
                y = $urandom_range(9999, 1);
            m   = $urandom_range(12, 1);
            len = sb.days_in_month(y, m);
            case ($urandom_range(9))
                0:       d = len + 1;                   // one past month end
                1, 2:    d = len;
                3:       d = 1;
                default: d = $urandom_range(len, 1);
            endcase
            req = date_request(y, m, d);
        end
        else if (pick < 50)
        begin
            // raw date fields over their full widths
            req = date_request($urandom_range(16383, 0), $urandom_range(15, 0),
                               $urandom_range(31, 0));
        end
        else if (pick < 70)
        begin
            // last day of a year or first day of the next one
            y        = $urandom_range(9999, 1);
            year_end = sb.convert_calendar(date_request(y, 12, 31));
            s        = year_end.serial_out;
            req      = serial_request(s + $urandom_range(1, 0));
        end
        else if (pick < 88)
        begin
            req = serial_request($urandom_range(gdn_pkg::MAX_SERIAL, 1));
        end
        else
        begin
            req = serial_request($urandom_range(4194303, 0));
        end
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, invalid dates, leap rules, range ends.
        send_request(date_request(1, 1, 1));            // day 1, a Monday
        send_request(date_request(9999, 12, 31));       // last supported day
        send_request(date_request(0, 1, 1));            // year zero
        send_request(date_request(10000, 1, 1));        // year above range
        send_request(date_request(16383, 15, 31));      // all input bits set
        send_request(date_request(2023, 0, 10));        // month zero
        send_request(date_request(2023, 13, 10));       // month thirteen
        send_request(date_request(2023, 5, 0));         // day zero
        send_request(date_request(2023, 4, 31));        // past a 30-day month
        send_request(date_request(2023, 1, 31));
        send_request(date_request(2023, 2, 29));        // non-leap February
        send_request(date_request(2024, 2, 29));        // leap by four
        send_request(date_request(1900, 2, 29));        // century, not leap
        send_request(date_request(2000, 2, 29));        // 400-year leap
        send_request(date_request(2000, 12, 31));       // day 366
        send_request(serial_request(0));
        send_request(serial_request(1));
        send_request(serial_request(365));
        send_request(serial_request(366));
        send_request(serial_request(1461));             // end of first 4-year span
        send_request(serial_request(146096));
        send_request(serial_request(146097));           // end of a 400-year cycle
        send_request(serial_request(gdn_pkg::MAX_SERIAL));
        send_request(serial_request(gdn_pkg::MAX_SERIAL + 1));
        send_request(serial_request(4194303));

        // Random phase, with one gap-free window in the middle.
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == 400)
                steady_flow <= 1'b1;
            else if (i == 600)
                steady_flow <= 1'b0;
            send_request(random_request());
        end
        in_valid <= 1'b0;

        // Drain; the watchdog covers a pipeline that never answers.
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            sb.failures++;
        end

        $display("Covered %0d result beats: %0d date-to-serial, %0d serial-to-date requests.",
                 sb.checked_beats, sb.date_requests, sb.serial_requests);
        $display("Of these, %0d were rejected as bad dates or out-of-range serials.",
                 sb.rejections);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
